// ===== hdl/czb_pkg.sv =====
// Shared constants, types and microprogram for the centre-zero bar graph sequencer.
`default_nettype none

package czb_pkg;

  // Bar and run sizing
  localparam int MAX_BARS    = 24;
  localparam int MAX_RESULTS = 30;
  localparam int BAR_W       = ($clog2(MAX_BARS + 1) < 2) ? 2 : $clog2(MAX_BARS + 1);
  localparam int HALF_MAX    = (MAX_BARS + 1) / 3;
  localparam int HALF_W      = ($clog2(HALF_MAX + 1) < 1) ? 1 : $clog2(HALF_MAX + 1);
  localparam int CNT_W       = $clog2(2 * HALF_MAX + 2);
  localparam int RES_W       = $clog2(MAX_RESULTS);

  // Divide by three through a reciprocal: exact for dividends below 512
  localparam int RECIP3       = 171;
  localparam int RECIP3_SHIFT = 9;

  // Stream payload widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  // LCD command codes
  typedef enum logic [1:0] {
    CMD_CURSOR = 2'd0,
    CMD_LTR    = 2'd1,
    CMD_RTL    = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_e;

  // Character codes
  localparam logic [7:0] BLANK_CHAR    = 8'd32;
  localparam logic [7:0] GLYPH_FULL    = 8'd0;
  localparam logic [7:0] GLYPH_MARK    = 8'd1;
  localparam logic [7:0] GLYPH_MARK_R  = 8'd2;
  localparam logic [7:0] GLYPH_MARK_L  = 8'd3;
  localparam logic [7:0] GLYPH_ONE_R   = 8'd4;
  localparam logic [7:0] GLYPH_ONE_L   = 8'd5;
  localparam logic [7:0] GLYPH_TWO_R   = 8'd6;
  localparam logic [7:0] GLYPH_TWO_L   = 8'd7;

  // Control word fields
  typedef enum logic [1:0] {
    COL_NONE   = 2'd0,
    COL_BLANK  = 2'd1,
    COL_CENTRE = 2'd2
  } col_sel_e;

  typedef enum logic [1:0] {
    CHR_NONE  = 2'd0,
    CHR_BLANK = 2'd1,
    CHR_MARK  = 2'd2,
    CHR_BAR   = 2'd3
  } chr_sel_e;

  typedef enum logic [1:0] {
    MAG_HOLD = 2'd0,
    MAG_MARK = 2'd1,
    MAG_BAR  = 2'd2
  } mag_op_e;

  typedef enum logic [1:0] {
    LOOP_NONE = 2'd0,
    LOOP_CNT  = 2'd1,
    LOOP_HOLD = 2'd2
  } loop_e;

  typedef enum logic [1:0] {
    END_NONE   = 2'd0,
    END_MARK   = 2'd1,
    END_BAR    = 2'd2,
    END_ALWAYS = 2'd3
  } end_sel_e;

  typedef struct packed {
    cmd_e     cmd;
    logic     dir_sign;
    col_sel_e col_sel;
    chr_sel_e chr_sel;
    logic     cnt_load;
    logic     cnt_dec;
    mag_op_e  mag_op;
    loop_e    loop_sel;
    end_sel_e end_sel;
  } ucode_t;

  // Values derived from one request at load time
  typedef struct packed {
    logic              neg;
    logic [BAR_W-1:0]  mag;
    logic [HALF_W-1:0] half;
  } bar_load_t;

  // Microprogram steps
  localparam int PROG_LEN = 7;
  localparam int PC_W     = $clog2(PROG_LEN);

  localparam logic [PC_W-1:0] STEP_CUR_BLANK = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_LTR       = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_BLANK     = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_CUR_CTR   = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_DIR       = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_MARK      = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_BAR       = PC_W'(6);

  // Read-only control store
  function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc);
    ucode_t w;
    w.cmd      = CMD_WRITE;
    w.dir_sign = 1'b0;
    w.col_sel  = COL_NONE;
    w.chr_sel  = CHR_NONE;
    w.cnt_load = 1'b0;
    w.cnt_dec  = 1'b0;
    w.mag_op   = MAG_HOLD;
    w.loop_sel = LOOP_NONE;
    w.end_sel  = END_NONE;
    unique case (pc)
      STEP_CUR_BLANK: begin
        w.cmd     = CMD_CURSOR;
        w.col_sel = COL_BLANK;
      end
      STEP_LTR: begin
        w.cmd      = CMD_LTR;
        w.cnt_load = 1'b1;
      end
      STEP_BLANK: begin
        w.chr_sel  = CHR_BLANK;
        w.cnt_dec  = 1'b1;
        w.loop_sel = LOOP_CNT;
      end
      STEP_CUR_CTR: begin
        w.cmd     = CMD_CURSOR;
        w.col_sel = COL_CENTRE;
      end
      STEP_DIR: begin
        w.cmd      = CMD_LTR;
        w.dir_sign = 1'b1;
      end
      STEP_MARK: begin
        w.chr_sel = CHR_MARK;
        w.mag_op  = MAG_MARK;
        w.end_sel = END_MARK;
      end
      STEP_BAR: begin
        w.chr_sel  = CHR_BAR;
        w.mag_op   = MAG_BAR;
        w.loop_sel = LOOP_HOLD;
        w.end_sel  = END_BAR;
      end
      default: begin
        w.end_sel = END_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/czb_bar_math.sv =====
// Request decode: limit saturation, magnitude clamp and blank half width.
`default_nettype none

module czb_bar_math (
  input  wire logic [15:0]          bar_value_i,
  input  wire logic [7:0]           bar_limit_i,
  output czb_pkg::bar_load_t        load_o
);

  logic                           neg;
  logic [15:0]                    abs_val;
  logic [czb_pkg::BAR_W-1:0]      lim;
  logic [czb_pkg::BAR_W+8:0]      lim_inc;
  logic [czb_pkg::BAR_W+8:0]      prod;

  // Saturate the limit and clamp the magnitude; -32768 stays 0x8000 unsigned
  always_comb begin
    neg     = bar_value_i[15];
    abs_val = neg ? 16'(~bar_value_i + 16'd1) : bar_value_i;
    lim     = (bar_limit_i > 8'(czb_pkg::MAX_BARS)) ? czb_pkg::BAR_W'(czb_pkg::MAX_BARS)
                                                    : czb_pkg::BAR_W'(bar_limit_i);
  end

  // Half blank width is (limit + 1) / 3 through a reciprocal multiply
  always_comb begin
    lim_inc = (czb_pkg::BAR_W + 9)'(lim) + (czb_pkg::BAR_W + 9)'(1);
    prod    = lim_inc * (czb_pkg::BAR_W + 9)'(czb_pkg::RECIP3);
  end

  always_comb begin
    load_o.neg  = neg;
    load_o.mag  = (abs_val > 16'(lim)) ? lim : czb_pkg::BAR_W'(abs_val);
    load_o.half = czb_pkg::HALF_W'(prod >> czb_pkg::RECIP3_SHIFT);
  end

endmodule

`default_nettype wire

// ===== hdl/centre_zero_bargraph_char_sequencer_core.sv =====
// Top level: microcoded command sequencer for a centre-zero LCD bar graph.
//
//   Channel  Dir  Handshake              Payload
//   s_axis   in   tvalid/tready          tdata: bar_value, bar_limit, centre_column, display_row
//   m_axis   out  tvalid/tready, tlast   tdata: cursor_column, cursor_row, char_code; tuser: command
//
// A request is first loaded, then one command per cycle, while m_axis does not stall, comes from a
// seven-step control store; a run is 2 + (2*half+1) + 3 + full commands, plus one more when
// bars are left over, at most 30. The single output register sets the pace: a stalled
// m_axis holds the sequencer on its current step. s_axis is ready only between runs, and
// it may accept while the final command still waits.
// Reset is asynchronous, active low, and leaves the sequencer idle.
`default_nettype none

module centre_zero_bargraph_char_sequencer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // [15:0] bar_value, [23:16] bar_limit, [31:24] centre_column, [33:32] display_row
  input  wire logic [czb_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] cursor_column, [9:8] cursor_row, [17:10] char_code
  output      logic [czb_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // [1:0] command
  output      logic [1:0]  m_axis_tuser_o,
  output      logic        m_axis_tlast_o
);

  czb_pkg::bar_load_t             load;
  czb_pkg::ucode_t                cw;

  logic                           busy_q, busy_d;
  logic [czb_pkg::PC_W-1:0]       pc_q, pc_d;
  logic [czb_pkg::RES_W-1:0]      res_cnt_q, res_cnt_d;
  logic [czb_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [czb_pkg::BAR_W-1:0]      ml_q, ml_d;
  logic                           out_valid_q, out_valid_d;
  logic                           neg_q;
  logic [czb_pkg::HALF_W-1:0]     half_q;
  logic [7:0]                     centre_q;
  logic [1:0]                     row_q;
  logic [czb_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [1:0]                     out_cmd_q;
  logic                           out_last_q;

  logic                           accept;
  logic                           fire;
  czb_pkg::cmd_e                  step_cmd;
  logic [7:0]                     step_col;
  logic [1:0]                     step_row;
  logic [7:0]                     step_chr;
  logic                           step_end;
  logic                           step_last;

  czb_bar_math u_bar_math (
    .bar_value_i (s_axis_tdata_i[15:0]),
    .bar_limit_i (s_axis_tdata_i[23:16]),
    .load_o      (load)
  );

  assign s_axis_tready_o = !busy_q;
  assign accept          = s_axis_tvalid_i && !busy_q;
  assign fire            = busy_q && (!out_valid_q || m_axis_tready_i);
  assign cw              = czb_pkg::ucode_word(pc_q);

  // Decode the current control word into one command
  always_comb begin
    step_cmd = (cw.dir_sign && neg_q) ? czb_pkg::CMD_RTL : cw.cmd;

    unique case (cw.col_sel)
      czb_pkg::COL_BLANK:  step_col = centre_q - 8'(half_q);
      czb_pkg::COL_CENTRE: step_col = centre_q;
      default:             step_col = 8'd0;
    endcase
    step_row = (cw.col_sel == czb_pkg::COL_NONE) ? 2'd0 : row_q;

    unique case (cw.chr_sel)
      czb_pkg::CHR_BLANK: step_chr = czb_pkg::BLANK_CHAR;
      czb_pkg::CHR_MARK: begin
        if (ml_q == '0) begin
          step_chr = czb_pkg::GLYPH_MARK;
        end else begin
          step_chr = neg_q ? czb_pkg::GLYPH_MARK_L : czb_pkg::GLYPH_MARK_R;
        end
      end
      czb_pkg::CHR_BAR: begin
        if (ml_q >= czb_pkg::BAR_W'(3)) begin
          step_chr = czb_pkg::GLYPH_FULL;
        end else if (ml_q == czb_pkg::BAR_W'(2)) begin
          step_chr = neg_q ? czb_pkg::GLYPH_TWO_L : czb_pkg::GLYPH_TWO_R;
        end else begin
          step_chr = neg_q ? czb_pkg::GLYPH_ONE_L : czb_pkg::GLYPH_ONE_R;
        end
      end
      default: step_chr = 8'd0;
    endcase

    unique case (cw.end_sel)
      czb_pkg::END_MARK:   step_end = (ml_q <= czb_pkg::BAR_W'(1));
      czb_pkg::END_BAR:    step_end = (ml_q <= czb_pkg::BAR_W'(3));
      czb_pkg::END_ALWAYS: step_end = 1'b1;
      default:             step_end = 1'b0;
    endcase

    // Cut the run at the result cap
    step_last = step_end || (res_cnt_q == czb_pkg::RES_W'(czb_pkg::MAX_RESULTS - 1));
  end

  // Advance the step counter, loop counters and output slot
  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    res_cnt_d   = res_cnt_q;
    cnt_d       = cnt_q;
    ml_d        = ml_q;
    out_valid_d = out_valid_q;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      busy_d    = 1'b1;
      pc_d      = czb_pkg::STEP_CUR_BLANK;
      res_cnt_d = '0;
      ml_d      = load.mag;
    end else if (fire) begin
      out_valid_d = 1'b1;
      res_cnt_d   = res_cnt_q + czb_pkg::RES_W'(1);

      if (cw.cnt_load) begin
        cnt_d = czb_pkg::CNT_W'({half_q, 1'b1});
      end else if (cw.cnt_dec) begin
        cnt_d = cnt_q - czb_pkg::CNT_W'(1);
      end

      unique case (cw.mag_op)
        czb_pkg::MAG_MARK: ml_d = (ml_q == '0) ? '0 : ml_q - czb_pkg::BAR_W'(1);
        czb_pkg::MAG_BAR:  ml_d = (ml_q >= czb_pkg::BAR_W'(3)) ? ml_q - czb_pkg::BAR_W'(3)
                                                               : '0;
        default:           ml_d = ml_q;
      endcase

      priority if (step_last) begin
        busy_d = 1'b0;
        pc_d   = czb_pkg::STEP_CUR_BLANK;
      end else if (cw.loop_sel == czb_pkg::LOOP_HOLD) begin
        pc_d = pc_q;
      end else if (cw.loop_sel == czb_pkg::LOOP_CNT && cnt_q != czb_pkg::CNT_W'(1)) begin
        pc_d = pc_q;
      end else begin
        pc_d = pc_q + czb_pkg::PC_W'(1);
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= czb_pkg::STEP_CUR_BLANK;
      res_cnt_q   <= '0;
      cnt_q       <= '0;
      ml_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      res_cnt_q   <= res_cnt_d;
      cnt_q       <= cnt_d;
      ml_q        <= ml_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture request payload and drive the output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q    <= load.neg;
      half_q   <= load.half;
      centre_q <= s_axis_tdata_i[31:24];
      row_q    <= s_axis_tdata_i[33:32];
    end
    if (fire) begin
      out_data_q <= czb_pkg::OUT_DATA_W'({step_chr, step_row, step_col});
      out_cmd_q  <= step_cmd;
      out_last_q <= step_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_cmd_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/czb_checker.sv =====
// Port-level checks on the sequencer output stream, bound to the top level.
`default_nettype none

module czb_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [czb_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic [1:0]                     m_axis_tuser_o,
  input wire logic                           m_axis_tlast_o
);

  // Hold a stalled command
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output request dropped while stalled");

  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // Only set-cursor carries a position
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != czb_pkg::CMD_CURSOR |->
      m_axis_tdata_o[9:0] == 10'd0)
    else $error("position set on a non-cursor command");

  // Only writes carry a character, and a run ends only on a write
  a_chr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != czb_pkg::CMD_WRITE |->
      m_axis_tdata_o[17:10] == 8'd0 && !m_axis_tlast_o)
    else $error("character or end flag on a non-write command");

endmodule

bind centre_zero_bargraph_char_sequencer_core czb_checker u_czb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
